// File: hw/rtl/ntcavg_pkg.sv
// ntcavg_pkg: widths, constants and shared result types of the thermistor converter.
// Used by the ring, the log2 unit, the divider, the top level and the bench; depends on nothing.
`timescale 1ns / 1ps

package ntcavg_pkg;

    // Default geometry
    localparam int RING_DEPTH_DEF = 16;
    localparam int BATCH_SIZE_DEF = 4;

    // Field and register widths
    localparam int SAMPLE_W = 10;
    localparam int RES_W    = 20;   // divider / nominal resistor registers
    localparam int TEMP_W   = 15;   // signed centi-degree values
    localparam int BETA_W   = 14;
    localparam int CFG_W    = 20;   // widest register
    localparam int IDX_W    = 2;

    // Logarithm unit
    localparam int LOG_W   = 40;    // operand width
    localparam int E_W     = 6;     // leading-one position
    localparam int FRAC_W  = 16;    // Q16 fraction
    localparam int LOGR_W  = E_W + FRAC_W;
    localparam int MANT_W  = 31;    // Q30 mantissa in [1,2)

    // Beta equation datapath
    localparam int L2_W    = LOGR_W + 1;        // signed log difference
    localparam int T0K_W   = 16;                // nominal temp in 0.01 K
    localparam int HB_W    = 21;                // 100 * beta
    localparam int PROD1_W = T0K_W + 1 + L2_W;  // t0k * l2, signed
    localparam int P_W     = PROD1_W + 17;      // * ln2, signed
    localparam int DEN_W   = 42;                // denominator, signed
    localparam int DV_W    = DEN_W - 1;         // positive denominator
    localparam int NUM_W   = HB_W + T0K_W + 16;
    localparam int X_W     = NUM_W + 1;
    localparam int Q_W     = 16;

    // Constants
    localparam logic [9:0]  FULL_SCALE   = 10'd1023;
    localparam int          KELVIN_CENTI = 27315;
    localparam logic [15:0] LN2_Q16      = 16'd45426;
    localparam int          T_MIN_CENTI  = -4000;
    localparam int          T_MAX_CENTI  = 15000;
    localparam logic [Q_W-1:0] TK_MIN = Q_W'(KELVIN_CENTI + T_MIN_CENTI);
    localparam logic [Q_W-1:0] TK_MAX = Q_W'(KELVIN_CENTI + T_MAX_CENTI);

    // Register reset values
    localparam logic [RES_W-1:0]  RS_RESET   = 20'd10000;
    localparam logic [RES_W-1:0]  R0_RESET   = 20'd10000;
    localparam logic [TEMP_W-1:0] T0_RESET   = 15'd2500;
    localparam logic [BETA_W-1:0] BETA_RESET = 14'd3950;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SERIES  = 2'd0;
    localparam logic [IDX_W-1:0] REG_NOMINAL = 2'd1;
    localparam logic [IDX_W-1:0] REG_T0      = 2'd2;
    localparam logic [IDX_W-1:0] REG_BETA    = 2'd3;

    // Log unit result
    typedef struct packed {
        logic              done;
        logic [LOGR_W-1:0] value;   // e * 2^16 + fraction
    } log_res_t;

    // Divider result
    typedef struct packed {
        logic           done;
        logic           ovf;        // quotient would not fit Q_W bits
        logic [Q_W-1:0] quot;
    } div_res_t;

endpackage

// File: hw/rtl/ntcavg_ring.sv
// ntcavg_ring: sample ring memory with write slot, fill count and running sum.
// Uses ntcavg_pkg for the sample width.
`timescale 1ns / 1ps

module ntcavg_ring #(
    parameter int RING_DEPTH = ntcavg_pkg::RING_DEPTH_DEF,
    parameter int SUM_W      = 14,
    parameter int FILL_W     = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd,      // store sample, update sum
    input  logic [ntcavg_pkg::SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]              sum,
    output logic [FILL_W-1:0]             filled
);
    import ntcavg_pkg::*;

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rd_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   filled_reg, filled_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                occupied;

    // Memory: read of the current slot is always registered
    always_ff @(posedge aclk) begin
        rd_reg <= ring_mem[slot_reg];
        if (upd) begin
            ring_mem[slot_reg] <= sample;
        end
    end

    // Next slot, fill count and sum
    always_comb begin
        occupied    = FILL_W'(slot_reg) < filled_reg;
        slot_next   = (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        filled_next = occupied ? filled_reg : FILL_W'(slot_reg) + 1'b1;
        sum_next    = sum_reg - (occupied ? SUM_W'(rd_reg) : '0) + SUM_W'(sample);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            filled_reg <= '0;
            sum_reg    <= '0;
        end else if (upd) begin
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            sum_reg    <= sum_next;
        end
    end

    assign sum    = sum_reg;
    assign filled = filled_reg;

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= FILL_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_W'(filled_reg) * SUM_W'(FULL_SCALE))
        else $error("running sum exceeds full scale times fill");
    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        upd |=> filled_reg >= $past(filled_reg))
        else $error("fill count decreased");

endmodule

// File: hw/rtl/ntcavg_log2.sv
// ntcavg_log2: iterative Q16 base-2 logarithm (normalize shift, then 16 squarings).
// Uses ntcavg_pkg for widths and the log_res_t result type.
`timescale 1ns / 1ps

module ntcavg_log2 (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ntcavg_pkg::LOG_W-1:0] operand,
    output ntcavg_pkg::log_res_t         res
);
    import ntcavg_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQ   = 3'b100
    } lstate_t;

    lstate_t             state_reg;
    logic [LOG_W-1:0]    v_reg;
    logic [E_W-1:0]      e_reg;
    logic [MANT_W-1:0]   m_reg, m_next;
    logic [FRAC_W-1:0]   frac_reg;
    logic [3:0]          cnt_reg;
    logic                done_reg;
    logic [LOGR_W-1:0]   val_reg;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_hi;
    logic                bit_set;

    // One squaring step of the mantissa
    always_comb begin
        sq      = m_reg * m_reg;
        sq_hi   = sq[2*MANT_W-1:MANT_W-1];
        bit_set = sq_hi[MANT_W];
        m_next  = bit_set ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (v_reg[LOG_W-1] || e_reg == '0) begin
                        state_reg <= L_SQ;
                    end
                end
                L_SQ: begin
                    if (cnt_reg == 4'd15) begin
                        state_reg <= L_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            L_IDLE: begin
                v_reg   <= operand;
                e_reg   <= E_W'(LOG_W - 1);
                cnt_reg <= '0;
            end
            L_NORM: begin
                if (v_reg[LOG_W-1] || e_reg == '0) begin
                    m_reg    <= v_reg[LOG_W-1 -: MANT_W];
                    frac_reg <= '0;
                end else begin
                    v_reg <= {v_reg[LOG_W-2:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
            end
            L_SQ: begin
                m_reg    <= m_next;
                frac_reg <= {frac_reg[FRAC_W-2:0], bit_set};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == 4'd15) begin
                    val_reg <= {e_reg, frac_reg[FRAC_W-2:0], bit_set};
                end
            end
            default: ;
        endcase
    end

    assign res.done  = done_reg;
    assign res.value = val_reg;

endmodule

// File: hw/rtl/ntcavg_div.sv
// ntcavg_div: restoring divider, 16 quotient bits one per cycle, with overflow check.
// Uses ntcavg_pkg for widths and the div_res_t result type.
`timescale 1ns / 1ps

module ntcavg_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ntcavg_pkg::X_W-1:0]  dividend,
    input  logic [ntcavg_pkg::DV_W-1:0] divisor,
    output ntcavg_pkg::div_res_t        res
);
    import ntcavg_pkg::*;

    localparam int SH_W = DV_W + Q_W - 1;

    logic               busy_reg;
    logic [4:0]         cnt_reg;
    logic [X_W-1:0]     rem_reg;
    logic [SH_W-1:0]    dsh_reg;
    logic [Q_W-1:0]     q_reg;
    logic               ovf_reg;
    logic               done_reg;
    logic               fits;

    // Trial subtract of the shifted divisor
    assign fits = SH_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd15) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {(Q_W-1){1'b0}}};
            ovf_reg <= (DV_W+Q_W)'(dividend) >= {divisor, {Q_W{1'b0}}};
            q_reg   <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - X_W'(dsh_reg);
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = q_reg;

endmodule

// File: hw/rtl/ntc_thermistor_average_to_temp.sv
// Flow: a sample that does not close a batch is accepted, then stored in the ring (update).
// A sample closing a batch then passes the range check, two log passes (normalize shift
// and 16 squarings each), 2 multiply steps, the denominator, 16 divider steps and the
// output load; a mean at a rail or a zero resistor goes from the check to the output load,
// a non-positive denominator skips the divider, and a full output register stalls.
// Throughput: one word at a time, s_tready high only while idle. Reset (aresetn, sync, low):
// ring empty, counters zero, registers at defaults.
`timescale 1ns / 1ps

module ntc_thermistor_average_to_temp #(
    parameter int RING_DEPTH = ntcavg_pkg::RING_DEPTH_DEF,
    parameter int BATCH_SIZE = ntcavg_pkg::BATCH_SIZE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [9:0] adc_sample
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [14:0] temperature_centi_c, [15] sensor_fault
    // Configuration writes
    input  logic                            cfg_we,
    input  logic [ntcavg_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ntcavg_pkg::CFG_W-1:0]    cfg_wdata
);
    import ntcavg_pkg::*;

    localparam int SUM_W   = $clog2(1023 * RING_DEPTH + 1);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int BATCH_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int PROD_W  = RES_W + SUM_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_UPD   = 13'b0000000000010,
        S_CHK   = 13'b0000000000100,
        S_LA0   = 13'b0000000001000,
        S_LA    = 13'b0000000010000,
        S_LB0   = 13'b0000000100000,
        S_LB    = 13'b0000001000000,
        S_MUL1  = 13'b0000010000000,
        S_MUL2  = 13'b0000100000000,
        S_DCALC = 13'b0001000000000,
        S_DIV0  = 13'b0010000000000,
        S_DIV   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [SAMPLE_W-1:0]         sample_reg;
    logic [BATCH_W-1:0]          batch_reg;

    logic [RES_W-1:0]            rs_reg, r0_reg;
    logic signed [TEMP_W-1:0]    t0_reg;
    logic [BETA_W-1:0]           beta_reg;

    logic [SUM_W-1:0]            sum;
    logic [FILL_W-1:0]           filled;
    logic [SUM_W-1:0]            full;
    logic [PROD_W-1:0]           opa, opb;
    logic [LOG_W-1:0]            opa_reg, opb_reg;

    log_res_t                    log_res;
    div_res_t                    div_res;
    logic                        log_start;
    logic [LOGR_W-1:0]           la_reg;
    logic signed [L2_W-1:0]      l2_reg;
    logic signed [PROD1_W-1:0]   prod1_reg;
    logic signed [P_W-1:0]       p_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [DV_W-1:0]             d_reg;

    logic [T0K_W-1:0]            t0k;
    logic [HB_W-1:0]             hb;
    logic signed [DEN_W-1:0]     den;
    logic [X_W-1:0]              x_val;

    logic signed [TEMP_W-1:0]    res_temp_reg;
    logic                        res_fault_reg;
    logic                        out_valid_reg;
    logic signed [TEMP_W-1:0]    out_temp_reg;
    logic                        out_fault_reg;
    logic                        accept;
    logic                        load_out;

    // Sample ring
    ntcavg_ring #(
        .RING_DEPTH (RING_DEPTH),
        .SUM_W      (SUM_W),
        .FILL_W     (FILL_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (state_reg == S_UPD),
        .sample  (sample_reg),
        .sum     (sum),
        .filled  (filled)
    );

    // Shared logarithm unit, used for both operands
    assign log_start = (state_reg == S_LA0) || (state_reg == S_LB0);

    ntcavg_log2 u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .operand ((state_reg == S_LA0) ? opa_reg : opb_reg),
        .res     (log_res)
    );

    // Final division
    ntcavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_DIV0),
        .dividend (x_val),
        .divisor  (d_reg),
        .res      (div_res)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg   <= RS_RESET;
            r0_reg   <= R0_RESET;
            t0_reg   <= T0_RESET;
            beta_reg <= BETA_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SERIES:  rs_reg   <= cfg_wdata;
                REG_NOMINAL: r0_reg   <= cfg_wdata;
                REG_T0:      t0_reg   <= cfg_wdata[TEMP_W-1:0];
                REG_BETA:    beta_reg <= cfg_wdata[BETA_W-1:0];
                default: ;
            endcase
        end
    end

    // Operands and derived constants
    always_comb begin
        full  = SUM_W'(filled) * SUM_W'(FULL_SCALE);
        opa   = PROD_W'(rs_reg) * PROD_W'(sum);
        opb   = PROD_W'(r0_reg) * PROD_W'(full - sum);
        t0k   = T0K_W'(17'(t0_reg) + 17'(KELVIN_CENTI));
        hb    = HB_W'(beta_reg) * HB_W'(100);
        den   = $signed({{(DEN_W-HB_W-16){1'b0}}, hb, 16'b0})
              + DEN_W'(p_reg >>> 16);
        x_val = X_W'(num_reg) + X_W'(d_reg >> 1);
    end

    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_UPD;
            S_UPD:   state_next = (batch_reg == BATCH_W'(BATCH_SIZE - 1)) ? S_CHK : S_IDLE;
            S_CHK: begin
                if (sum == '0 || rs_reg == '0 || sum >= full || r0_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_LA0;
                end
            end
            S_LA0:   state_next = S_LA;
            S_LA:    if (log_res.done) state_next = S_LB0;
            S_LB0:   state_next = S_LB;
            S_LB:    if (log_res.done) state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_DCALC;
            S_DCALC: state_next = (den <= 0) ? S_DONE : S_DIV0;
            S_DIV0:  state_next = S_DIV;
            S_DIV:   if (div_res.done) state_next = S_DONE;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            batch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_UPD) begin
                batch_reg <= (batch_reg == BATCH_W'(BATCH_SIZE - 1)) ? '0
                                                                      : batch_reg + 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        case (state_reg)
            S_CHK: begin
                opa_reg       <= LOG_W'(opa);
                opb_reg       <= LOG_W'(opb);
                res_fault_reg <= 1'b1;
                if (sum == '0 || rs_reg == '0) begin
                    res_temp_reg <= TEMP_W'(T_MAX_CENTI);
                end else begin
                    res_temp_reg <= TEMP_W'(T_MIN_CENTI);
                end
            end
            S_LA: begin
                if (log_res.done) la_reg <= log_res.value;
            end
            S_LB: begin
                if (log_res.done) begin
                    l2_reg <= $signed({1'b0, la_reg}) - $signed({1'b0, log_res.value});
                end
            end
            S_MUL1: begin
                prod1_reg <= $signed({1'b0, t0k}) * l2_reg;
                num_reg   <= {HB_W'(hb) * (HB_W+T0K_W)'(t0k), 16'b0};
            end
            S_MUL2: begin
                p_reg <= prod1_reg * $signed({1'b0, LN2_Q16});
            end
            S_DCALC: begin
                d_reg        <= den[DV_W-1:0];
                res_temp_reg <= TEMP_W'(T_MAX_CENTI);
                res_fault_reg <= 1'b1;
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (div_res.ovf || div_res.quot > TK_MAX) begin
                        res_temp_reg  <= TEMP_W'(T_MAX_CENTI);
                        res_fault_reg <= 1'b1;
                    end else if (div_res.quot < TK_MIN) begin
                        res_temp_reg  <= TEMP_W'(T_MIN_CENTI);
                        res_fault_reg <= 1'b1;
                    end else begin
                        res_temp_reg  <= TEMP_W'(17'(div_res.quot) - 17'(KELVIN_CENTI));
                        res_fault_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (load_out) begin
            out_temp_reg  <= res_temp_reg;
            out_fault_reg <= res_fault_reg;
        end
    end

    // Ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_fault_reg, out_temp_reg};

    // Checks
    a_accept_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_UPD)
        else $error("accepted word not followed by ring update");
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[15]) |->
            ($signed(m_tdata[14:0]) >= TEMP_W'(T_MIN_CENTI) &&
             $signed(m_tdata[14:0]) <= TEMP_W'(T_MAX_CENTI)))
        else $error("fault-free result out of range");
    a_log_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        log_res.done |-> (state_reg == S_LA || state_reg == S_LB))
        else $error("log result outside a log wait state");
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider result outside divide state");

endmodule

// File: tb/ntc_thermistor_average_to_temp_tb.sv
// Self-checking bench for the thermistor averager: drives ADC sample words and
// register writes, predicts batch temperatures and compares every result word.
// Depends on ntcavg_pkg and ntc_thermistor_average_to_temp.
`timescale 1ns / 1ps

module ntc_thermistor_average_to_temp_tb;
    import ntcavg_pkg::*;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     fault;
    } temp_result_t;

    // Scoreboard: own copy of registers and ring state, queue of expected temps
    class temp_scoreboard;
        logic [RES_W-1:0]         rs, r0;
        logic signed [TEMP_W-1:0] t0;
        logic [BETA_W-1:0]        beta;
        int                       ring [RING_DEPTH_DEF];
        int                       wslot, filled, batch, sum;
        temp_result_t             expected_temps [$];
        int                       errors, samples, results, faults;

        function new();
            rs = RS_RESET; r0 = R0_RESET; t0 = T0_RESET; beta = BETA_RESET;
            wslot = 0; filled = 0; batch = 0; sum = 0;
            errors = 0; samples = 0; results = 0; faults = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SERIES:  rs = data[RES_W-1:0];
                REG_NOMINAL: r0 = data[RES_W-1:0];
                REG_T0:      t0 = data[TEMP_W-1:0];
                REG_BETA:    beta = data[BETA_W-1:0];
                default: ;
            endcase
        endfunction

        // Q16 base-2 log: leading-one position plus 16 squaring steps
        function longint log2_q16(longint v);
            longint t, m, frac, e;
            if (v == 0) return 0;
            t = v; e = 0; frac = 0;
            while (t > 1) begin
                t = t >> 1;
                e++;
            end
            m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (longint'(2) << 30)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            return e * 65536 + frac;
        endfunction

        // Beta equation on the mean of the filled slots
        function temp_result_t beta_temp(longint s, longint n);
            temp_result_t r;
            longint full, t0k, l2, p, pf, d, num, tk;
            full = longint'(FULL_SCALE) * n;
            t0k = longint'(t0) + KELVIN_CENTI;
            r.fault = 1'b1;
            if (s == 0 || rs == 0) begin
                r.temp = TEMP_W'(T_MAX_CENTI);
                return r;
            end
            if (s >= full || r0 == 0) begin
                r.temp = TEMP_W'(T_MIN_CENTI);
                return r;
            end
            l2 = log2_q16(longint'(rs) * s) - log2_q16(longint'(r0) * (full - s));
            p = t0k * l2 * longint'(LN2_Q16);
            if (p >= 0) pf = p >> 16;
            else pf = -(((-p) + 65535) >> 16);
            d = 100 * longint'(beta) * 65536 + pf;
            if (d <= 0) begin
                r.temp = TEMP_W'(T_MAX_CENTI);
                return r;
            end
            num = 100 * longint'(beta) * t0k * 65536;
            tk = (num + d / 2) / d;
            if (tk < KELVIN_CENTI + T_MIN_CENTI) r.temp = TEMP_W'(T_MIN_CENTI);
            else if (tk > KELVIN_CENTI + T_MAX_CENTI) r.temp = TEMP_W'(T_MAX_CENTI);
            else begin
                r.temp = TEMP_W'(tk - KELVIN_CENTI);
                r.fault = 1'b0;
            end
            return r;
        endfunction

        // Accepted sample word: update ring, queue a temp at batch end
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            temp_result_t r;
            samples++;
            if (wslot < filled) sum -= ring[wslot];
            else filled = wslot + 1;
            ring[wslot] = int'(smp);
            sum += int'(smp);
            wslot = (wslot + 1) % RING_DEPTH_DEF;
            batch++;
            if (batch < BATCH_SIZE_DEF) return;
            batch = 0;
            r = beta_temp(sum, filled);
            expected_temps.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Result word against the oldest expected temp
        task check_result(logic [15:0] data);
            temp_result_t e;
            results++;
            if (expected_temps.size() == 0) begin
                report($sformatf("unexpected result word %h", data));
                return;
            end
            e = expected_temps.pop_front();
            if (data[14:0] !== e.temp)
                report($sformatf("temp %0d, expected %0d",
                                 $signed(data[14:0]), e.temp));
            if (data[15] !== e.fault)
                report($sformatf("fault %b, expected %b", data[15], e.fault));
            if (e.fault) faults++;
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;     // [9:0] adc_sample
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;          // [14:0] temperature_centi_c, [15] sensor_fault
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    temp_scoreboard sb = new();
    bit             calm = 1'b0;   // no idling on either side
    int unsigned    cycles = 0;
    localparam int unsigned CYCLE_LIMIT = 600000;

    ntc_thermistor_average_to_temp i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Monitor both channels at the edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_sample(s_tdata[SAMPLE_W-1:0]);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 7);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ntc_thermistor_average_to_temp_tb NOT OK");
            $finish;
        end
    end

    task send_sample(int smp);
        if (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= 16'(smp);
        do @(posedge aclk); while (!s_tready);
    endtask

    // One register write; the caller drops the write enable after the last one
    task write_reg(logic [IDX_W-1:0] idx, int data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(data);
        sb.set_reg(idx, CFG_W'(data));
        @(posedge aclk);
    endtask

    // Let every expected temp arrive, then let the sequencer settle
    task drain;
        s_tvalid <= 1'b0;
        while (sb.expected_temps.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task set_regs(int rs, int r0, int t0, int b);
        write_reg(REG_SERIES, rs);
        write_reg(REG_NOMINAL, r0);
        write_reg(REG_T0, t0);
        write_reg(REG_BETA, b);
        cfg_we <= 1'b0;
    endtask

    // Random samples: mostly uniform over the full range, some at or near the rails
    task random_samples(int count);
        int v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0:       v = 0;
                1:       v = 1023;
                2:       v = $urandom_range(1, 20);
                3:       v = $urandom_range(1000, 1022);
                default: v = $urandom_range(1023);
            endcase
            send_sample(v);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero mean, full-scale mean over a full ring, mid codes
        for (int i = 0; i < 4; i++) send_sample(0);
        for (int i = 0; i < 16; i++) send_sample(1023);
        send_sample(1); send_sample(512); send_sample(511); send_sample(1022);
        drain();

        // Corner register settings, including zero resistors and beta
        set_regs(1048575, 100, -4000, 1000);       random_samples(40); drain();
        set_regs(100, 1000000, 15000, 10000);      random_samples(40); drain();
        set_regs(0, 10000, 2500, 3950);            random_samples(20); drain();
        set_regs(10000, 0, 2500, 3950);            random_samples(20); drain();
        set_regs(10000, 10000, -16384, 16383);     random_samples(40); drain();
        set_regs(1000, 1048575, 16383, 0);         random_samples(40); drain();

        // Random settings; one phase without any idling
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 2);
            set_regs($urandom_range(100, 1000000), $urandom_range(100, 1000000),
                     int'($urandom_range(19000)) - 4000, $urandom_range(1000, 10000));
            random_samples(90);
            drain();
        end
        calm = 1'b0;

        $display("covered %0d samples and %0d temperature words (%0d saturated or faulted)",
                 sb.samples, sb.results, sb.faults);
        $display("across corner and random register settings with random back-pressure");
        if (sb.errors == 0) $display("ntc_thermistor_average_to_temp_tb OK");
        else $display("ntc_thermistor_average_to_temp_tb NOT OK");
        $finish;
    end
endmodule
